[hdl/hpd_pkg.sv]
// Shared types, constants, coefficient table and microprogram for the high-pass decimator.
`timescale 1ns / 1ps

package hpd_pkg;

	// Filter geometry
	localparam int TAP_COUNT    = 33;
	localparam int DECIM_FACTOR = 3;
	localparam int HIDX_W       = 6;
	localparam int PHASE_W      = 2;
	localparam int COEF_W       = 18;
	localparam int STEP_W       = 4;

	// Biquad coefficients, Q2.30
	localparam logic signed [31:0] HPF_B0 = 32'sd1065820337;
	localparam logic signed [31:0] HPF_B1 = -32'sd2131640684;
	localparam logic signed [31:0] HPF_B2 = 32'sd1065820337;
	localparam logic signed [31:0] HPF_A1 = -32'sd2131582240;
	localparam logic signed [31:0] HPF_A2 = 32'sd1057957293;

	// Multiplier operand pairs
	localparam logic [2:0] MS_B0X  = 3'd0;
	localparam logic [2:0] MS_B1X1 = 3'd1;
	localparam logic [2:0] MS_B2X2 = 3'd2;
	localparam logic [2:0] MS_A1Y1 = 3'd3;
	localparam logic [2:0] MS_A2Y2 = 3'd4;
	localparam logic [2:0] MS_FIR  = 3'd5;

	// Accumulate operations applied to the registered product
	localparam logic [1:0] ACC_NONE    = 2'd0;
	localparam logic [1:0] ACC_ADD_SHL = 2'd1;
	localparam logic [1:0] ACC_SUB_SAR = 2'd2;
	localparam logic [1:0] ACC_ADD     = 2'd3;

	// Sequencer operations
	localparam logic [2:0] SEQ_NEXT     = 3'd0;
	localparam logic [2:0] SEQ_WAIT_IN  = 3'd1;
	localparam logic [2:0] SEQ_LOOP     = 3'd2;
	localparam logic [2:0] SEQ_PHASE    = 3'd3;
	localparam logic [2:0] SEQ_WAIT_OUT = 3'd4;
	localparam logic [2:0] SEQ_JUMP     = 3'd5;

	// Program steps
	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] ST_B0    = 4'd1;
	localparam logic [STEP_W-1:0] ST_B1    = 4'd2;
	localparam logic [STEP_W-1:0] ST_B2    = 4'd3;
	localparam logic [STEP_W-1:0] ST_A1    = 4'd4;
	localparam logic [STEP_W-1:0] ST_A2    = 4'd5;
	localparam logic [STEP_W-1:0] ST_BWAIT = 4'd6;
	localparam logic [STEP_W-1:0] ST_BDONE = 4'd7;
	localparam logic [STEP_W-1:0] ST_FR0   = 4'd8;
	localparam logic [STEP_W-1:0] ST_FLOOP = 4'd9;
	localparam logic [STEP_W-1:0] ST_FLAST = 4'd10;
	localparam logic [STEP_W-1:0] ST_FWAIT = 4'd11;
	localparam logic [STEP_W-1:0] ST_FOUT  = 4'd12;

	typedef struct packed {
		logic [2:0]        m_sel;
		logic [1:0]        acc_op;
		logic              rd_en;
		logic              bq_done;
		logic              out_step;
		logic [2:0]        seq;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		ucode_t uc;
		logic   in_take;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic tap_last;
		logic phase_last;
		logic out_busy;
	} dp_stat_t;

	// Low-pass FIR coefficients, Q1.17, tap 0 applies to the newest sample
	function automatic logic signed [COEF_W-1:0] lp_coef(input logic [HIDX_W-1:0] idx);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			6'd0:  c = 18'sd56;
			6'd1:  c = 18'sd195;
			6'd2:  c = 18'sd199;
			6'd3:  c = -18'sd166;
			6'd4:  c = -18'sd762;
			6'd5:  c = -18'sd928;
			6'd6:  c = 18'sd0;
			6'd7:  c = 18'sd1747;
			6'd8:  c = 18'sd2741;
			6'd9:  c = 18'sd1178;
			6'd10: c = -18'sd2954;
			6'd11: c = -18'sd6675;
			6'd12: c = -18'sd5320;
			6'd13: c = 18'sd3969;
			6'd14: c = 18'sd19151;
			6'd15: c = 18'sd33449;
			6'd16: c = 18'sd39309;
			6'd17: c = 18'sd33449;
			6'd18: c = 18'sd19151;
			6'd19: c = 18'sd3969;
			6'd20: c = -18'sd5320;
			6'd21: c = -18'sd6675;
			6'd22: c = -18'sd2954;
			6'd23: c = 18'sd1178;
			6'd24: c = 18'sd2741;
			6'd25: c = 18'sd1747;
			6'd26: c = 18'sd0;
			6'd27: c = -18'sd928;
			6'd28: c = -18'sd762;
			6'd29: c = -18'sd166;
			6'd30: c = 18'sd199;
			6'd31: c = 18'sd195;
			6'd32: c = 18'sd56;
			default: c = 18'sd0;
		endcase
		return c;
	endfunction

	// Microprogram: one control word per step
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		unique case (step)
			ST_IDLE: begin
				w.seq = SEQ_WAIT_IN;
			end
			ST_B0: begin
				w.m_sel  = MS_B0X;
				w.acc_op = ACC_ADD_SHL;
			end
			ST_B1: begin
				w.m_sel  = MS_B1X1;
				w.acc_op = ACC_ADD_SHL;
			end
			ST_B2: begin
				w.m_sel  = MS_B2X2;
				w.acc_op = ACC_ADD_SHL;
			end
			ST_A1: begin
				w.m_sel  = MS_A1Y1;
				w.acc_op = ACC_SUB_SAR;
			end
			ST_A2: begin
				w.m_sel  = MS_A2Y2;
				w.acc_op = ACC_SUB_SAR;
			end
			ST_BWAIT: begin
				w.seq = SEQ_NEXT;
			end
			ST_BDONE: begin
				w.bq_done = 1'b1;
				w.seq     = SEQ_PHASE;
				w.target  = ST_IDLE;
			end
			ST_FR0: begin
				w.rd_en = 1'b1;
			end
			ST_FLOOP: begin
				w.rd_en  = 1'b1;
				w.m_sel  = MS_FIR;
				w.acc_op = ACC_ADD;
				w.seq    = SEQ_LOOP;
			end
			ST_FLAST: begin
				w.m_sel  = MS_FIR;
				w.acc_op = ACC_ADD;
			end
			ST_FWAIT: begin
				w.seq = SEQ_NEXT;
			end
			ST_FOUT: begin
				w.out_step = 1'b1;
				w.seq      = SEQ_WAIT_OUT;
				w.target   = ST_IDLE;
			end
			default: begin
				w.seq    = SEQ_JUMP;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[hdl/hpd_sequencer.sv]
// Step counter and microprogram sequencer for the high-pass decimator.
`timescale 1ns / 1ps

module hpd_sequencer
	import hpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	ucode_t            uc;

	// Fetch the control word for the current step
	assign uc       = ucode_rom(step_q);
	assign in_ready = (uc.seq == SEQ_WAIT_IN);

	always_comb begin
		cmd          = '0;
		cmd.uc       = uc;
		cmd.in_take  = in_valid && in_ready;
		cmd.out_load = uc.out_step && !stat.out_busy;
	end

	// Pick the next step
	always_comb begin
		step_d = step_q;
		unique case (uc.seq)
			SEQ_NEXT: begin
				step_d = step_q + 1'b1;
			end
			SEQ_WAIT_IN: begin
				if (in_valid) begin
					step_d = step_q + 1'b1;
				end
			end
			SEQ_LOOP: begin
				if (stat.tap_last) begin
					step_d = step_q + 1'b1;
				end
			end
			SEQ_PHASE: begin
				if (stat.phase_last) begin
					step_d = step_q + 1'b1;
				end else begin
					step_d = uc.target;
				end
			end
			SEQ_WAIT_OUT: begin
				if (!stat.out_busy) begin
					step_d = uc.target;
				end
			end
			SEQ_JUMP: begin
				step_d = uc.target;
			end
			default: begin
				step_d = ST_IDLE;
			end
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_FOUT)
		else $error("sequencer left the program");

	a_loop_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_FLOOP && stat.tap_last) |=> step_q == ST_FLAST)
		else $error("tap loop did not exit after the last tap");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |=> step_q == ST_B0)
		else $error("accepted transaction did not start the biquad");
`endif

endmodule

[hdl/hpd_datapath.sv]
// Shared MAC, filter state, tap history memory and output register.
`timescale 1ns / 1ps

module hpd_datapath
	import hpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic signed [15:0] in_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] filtered_sample
);

	localparam logic signed [63:0] Y_RND = 64'sd134217728;
	localparam logic signed [63:0] R_RND = 64'sd536870912;
	localparam logic signed [63:0] Y_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Y_MIN = -64'sd2147483648;
	localparam logic signed [63:0] R_MAX = 64'sd32767;
	localparam logic signed [63:0] R_MIN = -64'sd32768;
	localparam logic [HIDX_W-1:0]  LAST_IDX = HIDX_W'(TAP_COUNT - 1);

	// Filter state
	logic signed [15:0]        x_q, x1_q, x2_q;
	logic signed [31:0]        y1_q, y2_q;
	logic [HIDX_W-1:0]         wslot_q;
	logic [HIDX_W-1:0]         rd_ptr_q;
	logic [HIDX_W-1:0]         k_q;
	logic [PHASE_W-1:0]        phase_q;

	// History memory with per-entry valid bits
	logic [31:0]               hist_mem [TAP_COUNT];
	logic [TAP_COUNT-1:0]      hvld_q;
	logic [31:0]               rd_data_q;
	logic                      rd_vld_q;
	logic signed [COEF_W-1:0]  coef_q;

	// MAC
	logic signed [31:0]        ma, md;
	logic signed [63:0]        prod_s1;
	logic [1:0]                pop_s1;
	logic signed [63:0]        acc_q;
	logic signed [63:0]        acc_term;

	// Rounding and saturation
	logic signed [63:0]        ysum, yq, rsum, rq;
	logic signed [31:0]        y_sat;
	logic signed [15:0]        r_sat;

	logic                      out_valid_q;
	logic signed [15:0]        filtered_q;

	assign stat.tap_last   = (k_q == LAST_IDX);
	assign stat.phase_last = (phase_q == PHASE_W'(DECIM_FACTOR - 1));
	assign stat.out_busy   = out_valid_q && !out_ready;

	// Select multiplier operands
	always_comb begin
		ma = HPF_B0;
		md = 32'(x_q);
		unique case (cmd.uc.m_sel)
			MS_B0X: begin
				ma = HPF_B0;
				md = 32'(x_q);
			end
			MS_B1X1: begin
				ma = HPF_B1;
				md = 32'(x1_q);
			end
			MS_B2X2: begin
				ma = HPF_B2;
				md = 32'(x2_q);
			end
			MS_A1Y1: begin
				ma = HPF_A1;
				md = y1_q;
			end
			MS_A2Y2: begin
				ma = HPF_A2;
				md = y2_q;
			end
			MS_FIR: begin
				ma = 32'(coef_q);
				md = rd_vld_q ? $signed(rd_data_q) : 32'sd0;
			end
			default: begin
				ma = '0;
				md = '0;
			end
		endcase
	end

	// Scale the registered product for the accumulator
	always_comb begin
		unique case (pop_s1)
			ACC_NONE:    acc_term = '0;
			ACC_ADD_SHL: acc_term = prod_s1 <<< 11;
			ACC_SUB_SAR: acc_term = -(prod_s1 >>> 2);
			ACC_ADD:     acc_term = prod_s1;
			default:     acc_term = '0;
		endcase
	end

	// Round half up and saturate the biquad and FIR sums
	always_comb begin
		ysum = acc_q + Y_RND;
		yq   = ysum >>> 28;
		if (yq > Y_MAX) begin
			y_sat = 32'sh7FFFFFFF;
		end else if (yq < Y_MIN) begin
			y_sat = 32'sh80000000;
		end else begin
			y_sat = yq[31:0];
		end
		rsum = acc_q + R_RND;
		rq   = rsum >>> 30;
		if (rq > R_MAX) begin
			r_sat = 16'sh7FFF;
		end else if (rq < R_MIN) begin
			r_sat = 16'sh8000;
		end else begin
			r_sat = rq[15:0];
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= ma * md;
	end

	// Accumulate op is registered alongside the product so the two stay aligned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1 <= ACC_NONE;
		end else begin
			pop_s1 <= cmd.uc.acc_op;
		end
	end

	// Accumulator: clear at the start of each sum, else add the product
	always_ff @(posedge clk) begin
		if (cmd.in_take || cmd.uc.bq_done) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_q + acc_term;
		end
	end

	// Latch the input sample
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			x_q <= in_sample;
		end
	end

	// Biquad delay line, history pointers and valid bits, tap counter and decimation phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q     <= '0;
			x2_q     <= '0;
			y1_q     <= '0;
			y2_q     <= '0;
			wslot_q  <= '0;
			rd_ptr_q <= '0;
			k_q      <= '0;
			phase_q  <= '0;
			hvld_q   <= '0;
		end else begin
			if (cmd.uc.bq_done) begin
				x2_q             <= x1_q;
				x1_q             <= x_q;
				y2_q             <= y1_q;
				y1_q             <= y_sat;
				hvld_q[wslot_q]  <= 1'b1;
				rd_ptr_q         <= wslot_q;
				wslot_q          <= (wslot_q == LAST_IDX) ? '0 : wslot_q + 1'b1;
				k_q              <= '0;
				phase_q          <= stat.phase_last ? '0 : phase_q + 1'b1;
			end else if (cmd.uc.rd_en) begin
				k_q      <= k_q + 1'b1;
				rd_ptr_q <= (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - 1'b1;
			end
		end
	end

	// History memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.uc.bq_done) begin
			hist_mem[wslot_q] <= y_sat;
		end
		if (cmd.uc.rd_en) begin
			rd_data_q <= hist_mem[rd_ptr_q];
			rd_vld_q  <= hvld_q[rd_ptr_q];
			coef_q    <= lp_coef(k_q);
		end
	end

	// Output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			filtered_q <= r_sat;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = filtered_q;

`ifndef SYNTHESIS
	a_wslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		wslot_q < HIDX_W'(TAP_COUNT) && rd_ptr_q < HIDX_W'(TAP_COUNT))
		else $error("history pointer out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(DECIM_FACTOR))
		else $error("decimation phase out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending transaction");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |=> acc_q == 64'sd0)
		else $error("accumulator not cleared at transaction start");
`endif

endmodule

[hdl/highpass_decimate_3to1.sv]
// Top level: high-pass biquad and 33-tap 3:1 FIR decimator on one shared MAC.
// Every third accepted sample runs the FIR after its biquad step and yields a result.
// Throughput is set by the single 32x32 multiplier running 5 biquad and 33 FIR products;
// a new sample is accepted only once the previous one has finished its program.
// Reset (arst_n, async low) clears filter state, decimation phase and history valid bits.
// A new sample is accepted while a finished result still waits in the output register.
`timescale 1ns / 1ps

module highpass_decimate_3to1
	import hpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] filtered_sample
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Microprogram control
	hpd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// MAC, state and history
	hpd_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_sample       (in_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_sample (filtered_sample)
	);

endmodule
